>>> hw/rtl/sipl_pkg.sv
// Shared codes and the per-cell command struct of the sorted insert list.
package sipl_pkg;

	localparam logic [1:0] MODE_SORTED = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// Command broadcast to every cell in the cycle an operation executes.
	typedef struct packed {
		logic ins_sorted;
		logic ins_tail;
		logic remove;
	} cell_cmd_t;

endpackage

>>> hw/rtl/sipl_req_if.sv
// Request channel: one list operation per item.
interface sipl_req_if #(
	parameter int KEY_WIDTH = 32,
	parameter int ID_WIDTH  = 8
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic [KEY_WIDTH-1:0] new_key;
	logic [ID_WIDTH-1:0]  item_id;

	modport source (output valid, output mode, output new_key, output item_id, input ready);
	modport sink   (input valid, input mode, input new_key, input item_id, output ready);
endinterface

>>> hw/rtl/sipl_rsp_if.sv
// Response channel: status, count and head entry after each operation.
interface sipl_rsp_if #(
	parameter int KEY_WIDTH = 32,
	parameter int ID_WIDTH  = 8,
	parameter int CNT_WIDTH = 5
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [CNT_WIDTH-1:0] entry_count;
	logic                 head_valid;
	logic [KEY_WIDTH-1:0] head_key;
	logic [ID_WIDTH-1:0]  head_id;

	modport source (output valid, output status, output entry_count, output head_valid,
		output head_key, output head_id, input ready);
	modport sink   (input valid, input status, input entry_count, input head_valid,
		input head_key, input head_id, output ready);
endinterface

>>> hw/rtl/sipl_cell.sv
// One list cell: holds a key, an id and a valid bit, and moves data to or from its neighbors.
module sipl_cell #(
	parameter int KEY_WIDTH = 32,
	parameter int ID_WIDTH  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sipl_pkg::cell_cmd_t  cmd,
	input  logic [KEY_WIDTH-1:0] new_key,
	input  logic [ID_WIDTH-1:0]  item_id,
	input  logic                 found,
	input  logic                 before_in,
	output logic                 before_out,
	input  logic [KEY_WIDTH-1:0] left_key,
	input  logic [ID_WIDTH-1:0]  left_id,
	input  logic                 left_valid,
	input  logic [KEY_WIDTH-1:0] right_key,
	input  logic [ID_WIDTH-1:0]  right_id,
	input  logic                 right_valid,
	output logic [KEY_WIDTH-1:0] key_q,
	output logic [ID_WIDTH-1:0]  id_q,
	output logic                 valid_q,
	output logic [KEY_WIDTH-1:0] key_d,
	output logic [ID_WIDTH-1:0]  id_d,
	output logic                 valid_d
);

	logic hit;
	logic tail;

	assign hit = valid_q & ((cmd.ins_sorted & (key_q > new_key)) |
		(cmd.remove & (id_q == item_id)));
	assign before_out = before_in | hit;
	// First empty cell behind the last valid one.
	assign tail = ~valid_q & left_valid;

	always_comb begin
		key_d   = key_q;
		id_d    = id_q;
		valid_d = valid_q;
		if (cmd.ins_sorted) begin
			if (before_in & left_valid) begin
				key_d = left_key;
				id_d  = left_id;
			end else if ((hit & ~before_in) | (tail & ~found)) begin
				key_d = new_key;
				id_d  = item_id;
			end
			valid_d = valid_q | tail;
		end else if (cmd.ins_tail) begin
			if (tail) begin
				key_d = new_key;
				id_d  = item_id;
			end
			valid_d = valid_q | tail;
		end else if (cmd.remove & found & (before_in | hit)) begin
			// close up: take the entry behind
			key_d   = right_key;
			id_d    = right_id;
			valid_d = right_valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		id_q  <= id_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

endmodule

>>> hw/rtl/sorted_insert_priority_list_top.sv
// Sorted insert priority list: request stage, chain of cells and response register.
//
// Usage: each request item carries mode (0 sorted insert, 1 append at tail,
// 2 remove by id), new_key and item_id. A sorted insert lands after every
// entry whose key is less than or equal to its own; a remove takes out the
// first entry, from the head, with a matching id. Each request yields exactly
// one response item with status (0 done, 1 full and dropped, 2 id not found),
// the entry count after the operation and the head entry (zero when empty).
// A request accepted into the request stage executes against the cells when
// the response register can take its result. Throughput: one item per cycle
// while responses are taken; all cells compare in parallel and a one-bit
// prefix chain passes from cell to cell to find the insert or remove point,
// so that chain and the key compare set the cycle time.
// Reset clears the count and all cell valid bits; the list starts empty and
// no clearing pass is needed. When the receiver stalls, the response register
// holds its item, one more request waits in the request stage, and then
// req.ready drops until the response is taken.
module sorted_insert_priority_list_top #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32,
	parameter int ID_WIDTH  = 8
) (
	input logic       clk,
	input logic       arst_n,
	sipl_req_if.sink  req,
	sipl_rsp_if.source rsp
);

	localparam int CNT_WIDTH = $clog2(DEPTH + 1);

	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	logic [ID_WIDTH-1:0]  id_s1;
	logic [CNT_WIDTH-1:0] held_count_q;
	logic                 rsp_valid_q;
	logic                 fire;
	logic                 full;
	logic                 found;
	logic [1:0]           status;
	logic [CNT_WIDTH-1:0] count_d;
	sipl_pkg::cell_cmd_t  cmd;

	logic                 before_chain [DEPTH+1];
	logic [KEY_WIDTH-1:0] cell_key_q   [DEPTH];
	logic [ID_WIDTH-1:0]  cell_id_q    [DEPTH];
	logic                 cell_valid_q [DEPTH];
	logic [KEY_WIDTH-1:0] cell_key_d   [DEPTH];
	logic [ID_WIDTH-1:0]  cell_id_d    [DEPTH];
	logic                 cell_valid_d [DEPTH];

	assign fire      = valid_s1 & (~rsp_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | fire;
	assign full      = (held_count_q == CNT_WIDTH'(DEPTH));
	assign found     = before_chain[DEPTH];
	assign before_chain[0] = 1'b0;

	always_comb begin
		cmd     = '0;
		status  = sipl_pkg::STATUS_DONE;
		count_d = held_count_q;
		case (mode_s1)
			sipl_pkg::MODE_SORTED, sipl_pkg::MODE_APPEND: begin
				if (full) begin
					status = sipl_pkg::STATUS_FULL;
				end else begin
					cmd.ins_sorted = fire & (mode_s1 == sipl_pkg::MODE_SORTED);
					cmd.ins_tail   = fire & (mode_s1 == sipl_pkg::MODE_APPEND);
					count_d        = held_count_q + CNT_WIDTH'(1);
				end
			end
			sipl_pkg::MODE_REMOVE: begin
				cmd.remove = fire;
				if (found) begin
					count_d = held_count_q - CNT_WIDTH'(1);
				end else begin
					status = sipl_pkg::STATUS_NOT_FOUND;
				end
			end
			default: begin
				// unused mode: no change
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] lk;
		logic [ID_WIDTH-1:0]  li;
		logic                 lv;
		logic [KEY_WIDTH-1:0] rk;
		logic [ID_WIDTH-1:0]  ri;
		logic                 rv;

		if (i == 0) begin : g_head
			assign lk = key_s1;
			assign li = id_s1;
			assign lv = 1'b1;
		end else begin : g_inner_l
			assign lk = cell_key_q[i-1];
			assign li = cell_id_q[i-1];
			assign lv = cell_valid_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rk = '0;
			assign ri = '0;
			assign rv = 1'b0;
		end else begin : g_inner_r
			assign rk = cell_key_q[i+1];
			assign ri = cell_id_q[i+1];
			assign rv = cell_valid_q[i+1];
		end

		sipl_cell #(
			.KEY_WIDTH (KEY_WIDTH),
			.ID_WIDTH  (ID_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_key     (key_s1),
			.item_id     (id_s1),
			.found       (found),
			.before_in   (before_chain[i]),
			.before_out  (before_chain[i+1]),
			.left_key    (lk),
			.left_id     (li),
			.left_valid  (lv),
			.right_key   (rk),
			.right_id    (ri),
			.right_valid (rv),
			.key_q       (cell_key_q[i]),
			.id_q        (cell_id_q[i]),
			.valid_q     (cell_valid_q[i]),
			.key_d       (cell_key_d[i]),
			.id_d        (cell_id_d[i]),
			.valid_d     (cell_valid_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			held_count_q <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (fire) begin
				rsp_valid_q  <= 1'b1;
				held_count_q <= count_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid & req.ready) begin
			mode_s1 <= req.mode;
			key_s1  <= req.new_key;
			id_s1   <= req.item_id;
		end
		if (fire) begin
			rsp.status      <= status;
			rsp.entry_count <= count_d;
			rsp.head_valid  <= cell_valid_d[0];
			rsp.head_key    <= cell_valid_d[0] ? cell_key_d[0] : '0;
			rsp.head_id     <= cell_valid_d[0] ? cell_id_d[0] : '0;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

>>> hw/rtl/sipl_checker.sv
// Port-level checks for the sorted insert list, bound to the top level.
module sipl_checker #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32,
	parameter int ID_WIDTH  = 8,
	parameter int CNT_WIDTH = 5
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [1:0]           rsp_status,
	input logic [CNT_WIDTH-1:0] rsp_entry_count,
	input logic                 rsp_head_valid,
	input logic [KEY_WIDTH-1:0] rsp_head_key,
	input logic [ID_WIDTH-1:0]  rsp_head_id
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid & ~rsp_ready |=> rsp_valid & $stable(rsp_entry_count) &
		$stable(rsp_head_key) & $stable(rsp_status))
		else $error("response changed while stalled");

	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_head_valid == (rsp_entry_count != '0)))
		else $error("head valid disagrees with entry count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid & ~rsp_head_valid |-> (rsp_head_key == '0) && (rsp_head_id == '0))
		else $error("empty list shows a nonzero head");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_entry_count <= CNT_WIDTH'(DEPTH)) &&
		((rsp_status != sipl_pkg::STATUS_FULL) || (rsp_entry_count == CNT_WIDTH'(DEPTH))))
		else $error("entry count out of range or full status without full list");

endmodule

bind sorted_insert_priority_list_top sipl_checker #(
	.DEPTH     (DEPTH),
	.KEY_WIDTH (KEY_WIDTH),
	.ID_WIDTH  (ID_WIDTH),
	.CNT_WIDTH ($clog2(DEPTH + 1))
) u_sipl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count),
	.rsp_head_valid  (rsp.head_valid),
	.rsp_head_key    (rsp.head_key),
	.rsp_head_id     (rsp.head_id)
);
